### sv/assert_macros.svh
// assertion helpers for the list block
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// same-cycle implication
`define ASSERT_IMPL(lbl, ck, rstn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication
`define ASSERT_NEXT(lbl, ck, rstn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define ASSERT_IMPL(lbl, ck, rstn, ante, cons)
`define ASSERT_NEXT(lbl, ck, rstn, ante, cons)

`endif

`endif

### sv/iol_pkg.sv
`default_nettype none

package iol_pkg;

    localparam int CAPACITY_DEF = 64;
    localparam int POS_W        = 7;
    localparam int VAL_W        = 32;
    localparam int CNT_OUT_W    = 7;

    typedef enum logic [2:0] {
        OP_PUSH_FRONT = 3'd0,
        OP_POP_FRONT  = 3'd1,
        OP_APPEND     = 3'd2,
        OP_GET        = 3'd3,
        OP_PUT        = 3'd4,
        OP_INSERT     = 3'd5,
        OP_DELETE     = 3'd6,
        OP_CLEAR      = 3'd7
    } op_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_RANGE = 2'd2,
        ST_FULL  = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        ACT_HOLD  = 2'd0,
        ACT_WRITE = 2'd1,
        ACT_OPEN  = 2'd2,
        ACT_CLOSE = 2'd3
    } act_t;

    typedef struct packed {
        op_t                      opcode;
        logic [POS_W-1:0]         position;
        logic signed [VAL_W-1:0]  value;
    } cmd_t;

    typedef struct packed {
        logic signed [VAL_W-1:0]  read_value;
        logic [CNT_OUT_W-1:0]     count;
        logic                     list_empty;
        status_t                  status;
    } rsp_t;

    // broadcast control to every cell
    typedef struct packed {
        act_t                     action;
        logic signed [VAL_W-1:0]  value;
    } cell_ctl_t;

endpackage

`default_nettype wire

### sv/iol_cell.sv
`default_nettype none

module iol_cell #(
    parameter int IDX = 0,
    parameter int XW  = iol_pkg::POS_W
) (
    input  wire                                   clk,
    input  wire iol_pkg::cell_ctl_t               ctl,
    input  wire [XW-1:0]                          pos,
    input  wire logic signed [iol_pkg::VAL_W-1:0] left_data,
    input  wire logic signed [iol_pkg::VAL_W-1:0] right_data,
    output logic signed [iol_pkg::VAL_W-1:0]      data
);

    localparam logic [XW-1:0] MY_IDX = XW'(IDX);

    logic signed [iol_pkg::VAL_W-1:0] data_reg;
    logic signed [iol_pkg::VAL_W-1:0] data_next;

    always_comb
    begin
        data_next = data_reg;
        case (ctl.action)
            iol_pkg::ACT_HOLD:
            begin
                data_next = data_reg;
            end
            iol_pkg::ACT_WRITE:
            begin
                if (MY_IDX == pos)
                    data_next = ctl.value;
            end
            iol_pkg::ACT_OPEN:
            begin
                // cells past the gap take from the left
                if (MY_IDX > pos)
                    data_next = left_data;
                else if (MY_IDX == pos)
                    data_next = ctl.value;
            end
            iol_pkg::ACT_CLOSE:
            begin
                if (MY_IDX >= pos)
                    data_next = right_data;
            end
            default:
            begin
                data_next = data_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data = data_reg;

endmodule

`default_nettype wire

### sv/indexed_ordered_list_top.sv
// latency: one word accepted per cycle, its result strobed on the following cycle
// throughput: one word per clock, busy stays low; every cell shifts or holds in parallel
// the result has to be taken in its strobe cycle, the receiver cannot stall
// reset clears the length and the result strobe; cell contents stay undefined until written
`default_nettype none

`include "assert_macros.svh"

module indexed_ordered_list_top #(
    parameter int CAPACITY = iol_pkg::CAPACITY_DEF
) (
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire                 start,
    output logic                busy,
    input  wire iol_pkg::cmd_t  cmd,
    output logic                result_valid,
    output iol_pkg::rsp_t       rsp
);

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int XW = (CW > iol_pkg::POS_W) ? CW : iol_pkg::POS_W;
    localparam int AW = $clog2(CAPACITY);
    localparam logic [CW-1:0] CAP_CNT = CW'(CAPACITY);

    logic [CW-1:0]                    cnt_reg;
    logic [CW-1:0]                    cnt_next;
    logic                             strobe_reg;
    iol_pkg::rsp_t                    rsp_reg;
    iol_pkg::rsp_t                    rsp_next;
    iol_pkg::cell_ctl_t               ctl;
    logic [XW-1:0]                    cell_pos;
    logic signed [iol_pkg::VAL_W-1:0] cell_q [CAPACITY];
    logic                             accept;
    logic [XW-1:0]                    pos_x;
    logic [XW-1:0]                    cnt_x;
    logic                             is_full;
    logic                             no_elem;
    logic                             beyond;
    logic signed [iol_pkg::VAL_W-1:0] read_word;
    iol_pkg::status_t                 st;
    logic signed [iol_pkg::VAL_W-1:0] rd;
    logic                             rsp_rejected;

    assign busy   = 1'b0;
    assign accept = start && !busy;
    assign pos_x  = XW'(cmd.position);
    assign cnt_x  = XW'(cnt_reg);
    assign is_full = (cnt_reg == CAP_CNT);
    assign no_elem = (cnt_reg == '0);
    assign beyond  = (pos_x >= cnt_x);
    // only used once the index check has passed
    assign read_word = cell_q[pos_x[AW-1:0]];

    always_comb
    begin
        cnt_next   = cnt_reg;
        ctl.action = iol_pkg::ACT_HOLD;
        ctl.value  = cmd.value;
        cell_pos   = pos_x;
        st         = iol_pkg::ST_OK;
        rd         = '0;
        case (cmd.opcode)
            iol_pkg::OP_PUSH_FRONT:
            begin
                cell_pos = '0;
                if (is_full)
                    st = iol_pkg::ST_FULL;
                else
                begin
                    ctl.action = iol_pkg::ACT_OPEN;
                    cnt_next   = cnt_reg + 1'b1;
                end
            end
            iol_pkg::OP_POP_FRONT:
            begin
                cell_pos = '0;
                if (no_elem)
                    st = iol_pkg::ST_EMPTY;
                else
                begin
                    rd         = cell_q[0];
                    ctl.action = iol_pkg::ACT_CLOSE;
                    cnt_next   = cnt_reg - 1'b1;
                end
            end
            iol_pkg::OP_APPEND:
            begin
                cell_pos = cnt_x;
                if (is_full)
                    st = iol_pkg::ST_FULL;
                else
                begin
                    ctl.action = iol_pkg::ACT_OPEN;
                    cnt_next   = cnt_reg + 1'b1;
                end
            end
            iol_pkg::OP_GET:
            begin
                if (no_elem)
                    st = iol_pkg::ST_EMPTY;
                else if (beyond)
                    st = iol_pkg::ST_RANGE;
                else
                    rd = read_word;
            end
            iol_pkg::OP_PUT:
            begin
                if (no_elem)
                    st = iol_pkg::ST_EMPTY;
                else if (beyond)
                    st = iol_pkg::ST_RANGE;
                else
                    ctl.action = iol_pkg::ACT_WRITE;
            end
            iol_pkg::OP_INSERT:
            begin
                // range check wins over full
                if (pos_x > cnt_x)
                    st = iol_pkg::ST_RANGE;
                else if (is_full)
                    st = iol_pkg::ST_FULL;
                else
                begin
                    ctl.action = iol_pkg::ACT_OPEN;
                    cnt_next   = cnt_reg + 1'b1;
                end
            end
            iol_pkg::OP_DELETE:
            begin
                if (no_elem)
                    st = iol_pkg::ST_EMPTY;
                else if (beyond)
                    st = iol_pkg::ST_RANGE;
                else
                begin
                    ctl.action = iol_pkg::ACT_CLOSE;
                    cnt_next   = cnt_reg - 1'b1;
                end
            end
            iol_pkg::OP_CLEAR:
            begin
                cnt_next = '0;
            end
            default:
            begin
                cnt_next = cnt_reg;
            end
        endcase
        if (!accept)
        begin
            ctl.action = iol_pkg::ACT_HOLD;
            cnt_next   = cnt_reg;
        end
        rsp_next.read_value = rd;
        rsp_next.count      = iol_pkg::CNT_OUT_W'(cnt_next);
        rsp_next.list_empty = (cnt_next == '0);
        rsp_next.status     = st;
    end

    genvar gi;
    generate
        for (gi = 0; gi < CAPACITY; gi++)
        begin : g_cell
            logic signed [iol_pkg::VAL_W-1:0] left_w;
            logic signed [iol_pkg::VAL_W-1:0] right_w;
            if (gi == 0)
            begin : g_first
                assign left_w = '0;
            end
            else
            begin : g_left
                assign left_w = cell_q[gi-1];
            end
            if (gi == CAPACITY - 1)
            begin : g_last
                assign right_w = '0;
            end
            else
            begin : g_right
                assign right_w = cell_q[gi+1];
            end
            iol_cell #(
                .IDX (gi),
                .XW  (XW)
            ) u_cell (
                .clk        (clk),
                .ctl        (ctl),
                .pos        (cell_pos),
                .left_data  (left_w),
                .right_data (right_w),
                .data       (cell_q[gi])
            );
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg    <= '0;
            strobe_reg <= 1'b0;
        end
        else
        begin
            cnt_reg    <= cnt_next;
            strobe_reg <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            rsp_reg <= rsp_next;
    end

    assign result_valid = strobe_reg;
    assign rsp          = rsp_reg;
    assign rsp_rejected = result_valid && (rsp.status != iol_pkg::ST_OK);

    `ASSERT_IMPL(a_cnt_bound, clk, rst_n, 1'b1, cnt_reg <= CAP_CNT)
    `ASSERT_NEXT(a_word_result, clk, rst_n, accept, result_valid)
    `ASSERT_IMPL(a_reject_keeps_len, clk, rst_n, rsp_rejected, cnt_reg == $past(cnt_reg))
    `ASSERT_IMPL(a_len_matches, clk, rst_n, result_valid, rsp.count == iol_pkg::CNT_OUT_W'(cnt_reg))

endmodule

`default_nettype wire
